// ===== hw/rtl/cdn_pkg.sv =====
// ----------------------------------------------------------------------------
// cdn_pkg
// Shared types and constants for the calendar date to day number converter.
// ----------------------------------------------------------------------------
package cdn_pkg;

  // field widths
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned FracW  = 16;
  localparam int unsigned YearW  = 15;
  localparam int unsigned DnumW  = 40;

  // calendar constants
  localparam int SwitchYear  = 1582;
  localparam int SwitchMonth = 10;
  localparam int SwitchDay   = 15;
  localparam int EpochOffset = 694025;

  // reciprocal of 100 for years below 2**14: floor(y * 5243 / 2**19)
  localparam int unsigned Div100Mul   = 5243;
  localparam int unsigned Div100Shift = 19;

  // one converted request
  typedef struct packed {
    logic signed [DnumW-1:0] day_number;
    logic                    gregorian;
  } result_t;

  // days before the adjusted month m: trunc(30.6001 * (m + 1))
  function automatic logic [8:0] month_days(input logic [MonthW-1:0] m);
    logic [8:0] d;
    unique case (m)
      4'd0:    d = 9'd30;
      4'd1:    d = 9'd61;
      4'd2:    d = 9'd91;
      4'd3:    d = 9'd122;
      4'd4:    d = 9'd153;
      4'd5:    d = 9'd183;
      4'd6:    d = 9'd214;
      4'd7:    d = 9'd244;
      4'd8:    d = 9'd275;
      4'd9:    d = 9'd306;
      4'd10:   d = 9'd336;
      4'd11:   d = 9'd367;
      4'd12:   d = 9'd397;
      4'd13:   d = 9'd428;
      4'd14:   d = 9'd459;
      default: d = 9'd489;
    endcase
    return d;
  endfunction

endpackage

// ===== hw/rtl/calendar_date_to_day_number_top.sv =====
// ----------------------------------------------------------------------------
// calendar_date_to_day_number_top
// Converts a calendar date to a fixed-point day count since 1900 Jan 0.5.
// ----------------------------------------------------------------------------
// Usage:
//   A request carries month, day, day_fraction and a signed year on the in_
//   channel; it is taken at a clock edge where in_valid is high and in_stall
//   is low. Each request yields exactly one result on the out_ channel:
//   out_day_number (Q24.16 days, two's complement) and out_gregorian.
//   A request passes through the request register, then the conversion
//   logic into the result register, whose valid flag drives out_valid.
//   Throughput is one request per cycle while in_stall is low; each stage
//   advances whenever the stage after it is free.
//   When the receiver holds out_stall, the result stays put and the
//   request stage still fills; in_stall rises only once both stages hold
//   data and the result is stalled.
//   Reset (rst_n low at a clock edge) empties both stages; no clearing
//   pass is needed, the block accepts requests right after reset.
// ----------------------------------------------------------------------------
module calendar_date_to_day_number_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [cdn_pkg::MonthW-1:0]        in_month,
  input  logic [cdn_pkg::DayW-1:0]          in_day,
  input  logic [cdn_pkg::FracW-1:0]         in_day_fraction,
  input  logic signed [cdn_pkg::YearW-1:0]  in_year,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [cdn_pkg::DnumW-1:0]  out_day_number,
  output logic                              out_gregorian
);

  logic                             req_vld_r, req_vld_nxt;
  logic                             res_vld_r, res_vld_nxt;
  logic [cdn_pkg::MonthW-1:0]       month_r;
  logic [cdn_pkg::DayW-1:0]         day_r;
  logic [cdn_pkg::FracW-1:0]        frac_r;
  logic signed [cdn_pkg::YearW-1:0] year_r;
  cdn_pkg::result_t                 res_r;
  cdn_pkg::result_t                 calc_res;
  logic                             res_free;
  logic                             req_free;

  // stage flow control
  assign res_free    = !res_vld_r || !out_stall;
  assign req_free    = !req_vld_r || res_free;
  assign in_stall    = !req_free;
  assign res_vld_nxt = res_free ? req_vld_r : res_vld_r;
  assign req_vld_nxt = req_free ? in_valid : req_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      req_vld_r <= req_vld_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (req_free && in_valid) begin
      month_r <= in_month;
      day_r   <= in_day;
      frac_r  <= in_day_fraction;
      year_r  <= in_year;
    end
  end

  // conversion logic
  cdn_calc u_calc (
    .month        (month_r),
    .day          (day_r),
    .day_fraction (frac_r),
    .year         (year_r),
    .result       (calc_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (res_free && req_vld_r) begin
      res_r <= calc_res;
    end
  end

  assign out_valid      = res_vld_r;
  assign out_day_number = res_r.day_number;
  assign out_gregorian  = res_r.gregorian;

endmodule

// ===== hw/rtl/cdn_calc.sv =====
// ----------------------------------------------------------------------------
// cdn_calc
// Combinational date conversion between the request and result registers.
// ----------------------------------------------------------------------------
module cdn_calc (
  input  logic [cdn_pkg::MonthW-1:0]        month,
  input  logic [cdn_pkg::DayW-1:0]          day,
  input  logic [cdn_pkg::FracW-1:0]         day_fraction,
  input  logic signed [cdn_pkg::YearW-1:0]  year,
  output cdn_pkg::result_t                  result
);

  logic               early_month;
  logic signed [15:0] year_ext;
  logic signed [15:0] y_adj;
  logic               greg;
  logic signed [26:0] year_days;
  logic [26:0]        cent_prod;
  logic [7:0]         cent;
  logic signed [9:0]  corr;
  logic [3:0]         m_adj;
  logic [8:0]         mon_days;
  logic signed [25:0] whole;

  // january and february count as months 13 and 14 of the prior year
  assign early_month = (month < 4'd3);
  assign m_adj       = early_month ? (month + 4'd12) : month;
  assign mon_days    = cdn_pkg::month_days(m_adj);

  // no year zero: shift negative years up by one
  assign year_ext = 16'(year);
  assign y_adj    = year_ext + (year[cdn_pkg::YearW-1] ? 16'sd1 : 16'sd0)
                    - (early_month ? 16'sd1 : 16'sd0);

  // calendar choice at 15 october 1582
  always_comb begin
    priority if (year > 15'(cdn_pkg::SwitchYear)) begin
      greg = 1'b1;
    end else if (year == 15'(cdn_pkg::SwitchYear)) begin
      greg = (month > 4'(cdn_pkg::SwitchMonth)) ||
             ((month == 4'(cdn_pkg::SwitchMonth)) && (day >= 5'(cdn_pkg::SwitchDay)));
    end else begin
      greg = 1'b0;
    end
  end

  // century correction, only used for positive years
  assign cent_prod = 27'(y_adj[13:0]) * 27'(cdn_pkg::Div100Mul);
  assign cent      = cent_prod[cdn_pkg::Div100Shift +: 8];
  assign corr      = greg ? (10'sd2 - signed'({2'b00, cent}) + signed'({4'b0000, cent[7:2]}))
                          : 10'sd0;

  // 365.25 days per year, floored
  assign year_days = 27'(y_adj) * 27'sd1461;

  // whole days since the epoch
  assign whole = 26'(year_days >>> 2) + 26'(corr) - 26'sd694025
               + signed'({17'd0, mon_days}) + signed'({21'd0, day});

  // fixed point day count, epoch at noon
  assign result.day_number = signed'({whole[23:0], day_fraction}) - 40'sd32768;
  assign result.gregorian  = greg;

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives calendar dates into the day number converter over a valid/stall
// channel and compares every converted result against a stored value or a
// bit-exact integer predictor. A short edge-date table comes first, followed
// by random dates with random gaps, random result stalls and one long hold-off.
// ----------------------------------------------------------------------------
module testbench;

  localparam int RandomDates = 1530;

  // one row of the edge-date table; known rows carry their result
  typedef struct packed {
    logic [cdn_pkg::MonthW-1:0]        month;
    logic [cdn_pkg::DayW-1:0]          day;
    logic [cdn_pkg::FracW-1:0]         frac;
    logic signed [cdn_pkg::YearW-1:0]  year;
    logic                              known;
    cdn_pkg::result_t                  want;
  } date_row_t;

  localparam date_row_t EdgeDates [24] = '{
    // noon of 1900 jan 0 is the epoch itself
    '{4'd1,  5'd0,  16'h8000,  15'(1900), 1'b1, '{40'sd0, 1'b1}},
    '{4'd1,  5'd1,  16'h0000,  15'(1900), 1'b1, '{40'sd32768, 1'b1}},
    '{4'd1,  5'd0,  16'h7fff,  15'(1900), 1'b1, '{-40'sd1, 1'b1}},
    '{4'd12, 5'd31, 16'h8000,  15'(1899), 1'b1, '{40'sd0, 1'b1}},
    // calendar switch in october 1582
    '{4'd10, 5'd14, 16'hffff,  15'(1582), 1'b0, '{40'sd0, 1'b0}},
    '{4'd10, 5'd15, 16'h0000,  15'(1582), 1'b0, '{40'sd0, 1'b0}},
    '{4'd9,  5'd30, 16'h0000,  15'(1582), 1'b0, '{40'sd0, 1'b0}},
    '{4'd11, 5'd1,  16'h0000,  15'(1582), 1'b0, '{40'sd0, 1'b0}},
    // month zero, months past twelve and a leap day
    '{4'd0,  5'd1,  16'h0000,  15'(1582), 1'b0, '{40'sd0, 1'b0}},
    '{4'd13, 5'd1,  16'h0000,  15'(1582), 1'b0, '{40'sd0, 1'b0}},
    '{4'd15, 5'd31, 16'hffff,  15'(1582), 1'b0, '{40'sd0, 1'b0}},
    '{4'd14, 5'd0,  16'h0000,  15'(2000), 1'b0, '{40'sd0, 1'b0}},
    '{4'd2,  5'd29, 16'h0000,  15'(2000), 1'b0, '{40'sd0, 1'b0}},
    // around the missing year zero
    '{4'd3,  5'd1,  16'h0000,  15'(-1),   1'b0, '{40'sd0, 1'b0}},
    '{4'd1,  5'd1,  16'h0000,  15'(1),    1'b0, '{40'sd0, 1'b0}},
    '{4'd6,  5'd15, 16'h1234,  15'(0),    1'b0, '{40'sd0, 1'b0}},
    // stated year range and the full field range
    '{4'd1,  5'd1,  16'h0000,  15'(-9999),  1'b0, '{40'sd0, 1'b0}},
    '{4'd12, 5'd31, 16'hffff,  15'(9999),   1'b0, '{40'sd0, 1'b0}},
    '{4'd0,  5'd0,  16'h0000,  15'(-16384), 1'b0, '{40'sd0, 1'b0}},
    '{4'd15, 5'd31, 16'hffff,  15'(16383),  1'b0, '{40'sd0, 1'b0}},
    // assorted history and century edges
    '{4'd7,  5'd4,  16'haaaa,  15'(1776),  1'b0, '{40'sd0, 1'b0}},
    '{4'd2,  5'd28, 16'h5555,  15'(-4713), 1'b0, '{40'sd0, 1'b0}},
    '{4'd8,  5'd0,  16'h0000,  15'(100),   1'b0, '{40'sd0, 1'b0}},
    '{4'd3,  5'd1,  16'h0000,  15'(-101),  1'b0, '{40'sd0, 1'b0}}
  };

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  logic [cdn_pkg::MonthW-1:0]        in_month;
  logic [cdn_pkg::DayW-1:0]          in_day;
  logic [cdn_pkg::FracW-1:0]         in_day_fraction;
  logic signed [cdn_pkg::YearW-1:0]  in_year;
  logic                              out_valid;
  logic                              out_stall;
  logic signed [cdn_pkg::DnumW-1:0]  out_day_number;
  logic                              out_gregorian;

  cdn_pkg::result_t due_days_q[$];
  logic    calm;
  int      dates_sent;
  int      days_checked;
  int      gregorian_seen;
  int      input_held;
  int      errors;
  int      hold_left;
  logic    hold_done;

  calendar_date_to_day_number_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_month        (in_month),
    .in_day          (in_day),
    .in_day_fraction (in_day_fraction),
    .in_year         (in_year),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_day_number  (out_day_number),
    .out_gregorian   (out_gregorian)
  );

  // day count since 1900 jan 0.5 in q24.16, exact integer form
  function automatic cdn_pkg::result_t date_to_day_number(
      input logic [cdn_pkg::MonthW-1:0]       mon,
      input logic [cdn_pkg::DayW-1:0]         dd,
      input logic [cdn_pkg::FracW-1:0]        frac,
      input logic signed [cdn_pkg::YearW-1:0] yr_in);
    longint           yr, mo, dl, fl, y, m, a, corr, t, q, whole, fixed;
    cdn_pkg::result_t r;
    yr = yr_in;
    mo = mon;
    dl = dd;
    fl = frac;
    // no year zero; jan and feb belong to the prior year
    y = (yr < 0) ? yr + 1 : yr;
    m = mo;
    if (mo < 3) begin
      m = m + 12;
      y = y - 1;
    end
    // julian before the switch day, gregorian correction after
    if (yr < cdn_pkg::SwitchYear || (yr == cdn_pkg::SwitchYear &&
        (mo < cdn_pkg::SwitchMonth ||
         (mo == cdn_pkg::SwitchMonth && dl < cdn_pkg::SwitchDay)))) begin
      r.gregorian = 1'b0;
      corr = 0;
    end else begin
      a = y / 100;
      r.gregorian = 1'b1;
      corr = 2 - a + a / 4;
    end
    // floor of 1461*y/4
    t = 1461 * y;
    q = t / 4;
    if (t % 4 != 0 && t < 0) q = q - 1;
    whole = corr + q - cdn_pkg::EpochOffset + (306001 * (m + 1)) / 10000 + dl;
    fixed = whole * 65536 + fl - 32768;
    r.day_number = fixed[cdn_pkg::DnumW-1:0];
    return r;
  endfunction

  // offer one request, wait for acceptance, then queue its result
  task automatic send_date(input logic [cdn_pkg::MonthW-1:0] mo,
                           input logic [cdn_pkg::DayW-1:0] dd,
                           input logic [cdn_pkg::FracW-1:0] fr,
                           input logic signed [cdn_pkg::YearW-1:0] yr,
                           input logic known, input cdn_pkg::result_t want);
    while (!calm && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_month        <= mo;
    in_day          <= dd;
    in_day_fraction <= fr;
    in_year         <= yr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (known) due_days_q.push_back(want);
    else due_days_q.push_back(date_to_day_number(mo, dd, fr, yr));
    dates_sent++;
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #(12 * 100000);
    $display("testbench: done, errors");
    $finish;
  end

  // result side: random stalls, one long hold-off once results flow
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && days_checked >= 150) begin
      out_stall <= 1'b1;
      hold_left <= 60;
      hold_done <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 33);
    end
  end

  // compare each accepted result with the oldest queued one
  always @(posedge clk) begin
    cdn_pkg::result_t want;
    if (rst_n) begin
      if (in_valid && in_stall) input_held <= input_held + 1;
      if (out_valid && !out_stall) begin
        if (due_days_q.size() == 0) begin
          $error("unexpected result: day_number %0d gregorian %0d",
                 out_day_number, out_gregorian);
          errors++;
        end else begin
          want = due_days_q.pop_front();
          if (out_day_number !== want.day_number) begin
            $error("day_number: expected %0d, got %0d", want.day_number, out_day_number);
            errors++;
          end
          if (out_gregorian !== want.gregorian) begin
            $error("gregorian: expected %0d, got %0d", want.gregorian, out_gregorian);
            errors++;
          end
        end
        days_checked   <= days_checked + 1;
        gregorian_seen <= gregorian_seen + (out_gregorian ? 1 : 0);
      end
    end
  end

  // stimulus
  initial begin
    int                               pick;
    int                               yv;
    logic [cdn_pkg::MonthW-1:0]       mo;
    logic [cdn_pkg::DayW-1:0]         dd;
    logic [cdn_pkg::FracW-1:0]        fr;
    logic signed [cdn_pkg::YearW-1:0] yr;
    in_valid        <= 1'b0;
    in_month        <= '0;
    in_day          <= '0;
    in_day_fraction <= '0;
    in_year         <= '0;
    rst_n           <= 1'b0;
    calm            = 1'b0;
    dates_sent      = 0;
    days_checked    = 0;
    gregorian_seen  = 0;
    input_held      = 0;
    errors          = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // edge dates
    foreach (EdgeDates[i])
      send_date(EdgeDates[i].month, EdgeDates[i].day, EdgeDates[i].frac,
                EdgeDates[i].year, EdgeDates[i].known, EdgeDates[i].want);

    // random dates, with a stretch of back-to-back traffic in the middle
    for (int i = 0; i < RandomDates; i++) begin
      calm = (i >= 700 && i < 1000);
      pick = $urandom_range(99);
      fr = 16'($urandom_range(16'hffff));
      if (pick < 50) begin
        // well-formed date in the stated year range
        mo = 4'($urandom_range(12, 1));
        dd = 5'($urandom_range(31, 1));
        yv = int'($urandom_range(19998)) - 9999;
        yr = yv[cdn_pkg::YearW-1:0];
      end else if (pick < 65) begin
        // near the calendar switch
        mo = 4'($urandom_range(11, 9));
        dd = 5'($urandom_range(31, 1));
        yv = int'($urandom_range(2)) + 1581;
        yr = yv[cdn_pkg::YearW-1:0];
      end else if (pick < 80) begin
        // small years around zero and the first centuries
        mo = 4'($urandom_range(12, 1));
        dd = 5'($urandom_range(31, 1));
        yv = int'($urandom_range(1000)) - 500;
        yr = yv[cdn_pkg::YearW-1:0];
      end else begin
        // any bit pattern the fields allow
        mo = 4'($urandom_range(15));
        dd = 5'($urandom_range(31));
        yr = 15'($urandom_range(32767));
      end
      send_date(mo, dd, fr, yr, 1'b0, '0);
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // drain, then allow for the pipeline depth
    while (due_days_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("testbench: %0d dates converted (%0d from the edge table), %0d gregorian",
             days_checked, $size(EdgeDates), gregorian_seen);
    $display("testbench: input held back on %0d cycles during result stalls", input_held);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== calendar_date_to_day_number_top.f =====
hw/rtl/cdn_pkg.sv
hw/rtl/cdn_calc.sv
hw/rtl/calendar_date_to_day_number_top.sv
sim/testbench.sv
